FILE: sv/fbd_pkg.sv
// shared types, codes and the base64 character decode for the framed decoder
package fbd_pkg;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] FRAME_OPEN  = 8'h00;
  localparam logic [7:0] FRAME_CLOSE = 8'hFF;
  localparam logic [7:0] CH_PLUS     = 8'h2B;
  localparam logic [7:0] CH_SLASH    = 8'h2F;
  localparam logic [7:0] CH_PAD      = 8'h3D;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_FRAME = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;
  localparam logic [1:0] KIND_ERR   = 2'd3;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_HEADER = 2'd1;
  localparam logic [1:0] ERR_CHAR   = 2'd2;
  localparam logic [1:0] ERR_GROUP  = 2'd3;

  localparam logic [1:0] GRP_LAST = 2'd3;
  localparam logic [1:0] IDX_ONE  = 2'd0;
  localparam logic [1:0] IDX_TWO  = 2'd1;
  localparam logic [1:0] IDX_THREE = 2'd2;

  typedef struct packed {
    logic       bad;
    logic       pad;
    logic [5:0] val;
  } sxt_t;

  // one queued request: up to three results
  typedef struct packed {
    logic [1:0]      kind;
    logic [1:0]      err;
    logic [1:0]      last_idx;
    logic [2:0][7:0] bytes;
  } cmd_t;

  function automatic sxt_t sextet(input logic [7:0] c);
    sxt_t s;
    s = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      s.val = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      s.val = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s.val = 6'(c - 8'h30 + 8'd52);
    end else if (c == CH_PLUS) begin
      s.val = 6'd62;
    end else if (c == CH_SLASH) begin
      s.val = 6'd63;
    end else if (c == CH_PAD) begin
      s.pad = 1'b1;
    end else begin
      s.bad = 1'b1;
    end
    return s;
  endfunction

endpackage

FILE: sv/fbd_ifs.sv
// valid/ready channel interfaces for the input bytes and the results
interface fbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       stream_end;
  modport source (output valid, output in_byte, output stream_end, input ready);
  modport sink (input valid, input in_byte, input stream_end, output ready);
endinterface

interface fbd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [1:0] kind;
  logic [1:0] error_code;
  logic       last;
  modport source (output valid, output data_byte, output kind, output error_code,
                  output last, input ready);
  modport sink (input valid, input data_byte, input kind, input error_code,
                input last, output ready);
endinterface

FILE: sv/fbd_front.sv
// front end: framing, character checks, group collection and group decode
module fbd_front (
  input  logic          clk,
  input  logic          rst_n,
  fbd_in_if.sink        in_ch,
  input  logic          q_full,
  output logic          push,
  output fbd_pkg::cmd_t push_cmd
);

  logic         inside_r, inside_nxt;
  logic         halted_r, halted_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  logic         wr_en;
  fbd_pkg::sxt_t grp_r [3];
  fbd_pkg::sxt_t s_in;
  logic         acc;

  assign in_ch.ready = !q_full;
  assign acc  = in_ch.valid && in_ch.ready;
  assign s_in = fbd_pkg::sextet(in_ch.in_byte);

  always_comb begin
    push       = 1'b0;
    push_cmd   = '0;
    inside_nxt = inside_r;
    halted_nxt = halted_r;
    cnt_nxt    = cnt_r;
    wr_en      = 1'b0;
    if (acc && !halted_r) begin
      if (in_ch.stream_end) begin
        push       = 1'b1;
        halted_nxt = 1'b1;
        if (inside_r && cnt_r != 2'd0) begin
          push_cmd.kind = fbd_pkg::KIND_ERR;
          push_cmd.err  = fbd_pkg::ERR_GROUP;
        end else begin
          push_cmd.kind = fbd_pkg::KIND_END;
        end
      end else if (!inside_r) begin
        if (in_ch.in_byte != fbd_pkg::FRAME_OPEN) begin
          push          = 1'b1;
          halted_nxt    = 1'b1;
          push_cmd.kind = fbd_pkg::KIND_ERR;
          push_cmd.err  = fbd_pkg::ERR_HEADER;
        end else begin
          inside_nxt = 1'b1;
          cnt_nxt    = 2'd0;
        end
      end else if (in_ch.in_byte == fbd_pkg::FRAME_CLOSE) begin
        push = 1'b1;
        if (cnt_r != 2'd0) begin
          halted_nxt    = 1'b1;
          push_cmd.kind = fbd_pkg::KIND_ERR;
          push_cmd.err  = fbd_pkg::ERR_GROUP;
        end else begin
          inside_nxt    = 1'b0;
          push_cmd.kind = fbd_pkg::KIND_FRAME;
        end
      end else if (s_in.bad) begin
        push          = 1'b1;
        halted_nxt    = 1'b1;
        push_cmd.kind = fbd_pkg::KIND_ERR;
        push_cmd.err  = fbd_pkg::ERR_CHAR;
      end else if (cnt_r != fbd_pkg::GRP_LAST) begin
        wr_en   = 1'b1;
        cnt_nxt = cnt_r + 2'd1;
      end else begin
        cnt_nxt = 2'd0;
        push    = 1'b1;
        push_cmd.kind = fbd_pkg::KIND_DATA;
        push_cmd.bytes[0] = {grp_r[0].val, grp_r[1].val[5:4]};
        if (grp_r[0].pad || grp_r[1].pad) begin
          push_cmd = '0;
          push_cmd.kind = fbd_pkg::KIND_ERR;
          push_cmd.err  = fbd_pkg::ERR_GROUP;
          halted_nxt    = 1'b1;
        end else if (grp_r[2].pad) begin
          if (!s_in.pad || grp_r[1].val[3:0] != 4'd0) begin
            push_cmd = '0;
            push_cmd.kind = fbd_pkg::KIND_ERR;
            push_cmd.err  = fbd_pkg::ERR_GROUP;
            halted_nxt    = 1'b1;
          end else begin
            push_cmd.last_idx = fbd_pkg::IDX_ONE;
          end
        end else if (s_in.pad) begin
          if (grp_r[2].val[1:0] != 2'd0) begin
            push_cmd = '0;
            push_cmd.kind = fbd_pkg::KIND_ERR;
            push_cmd.err  = fbd_pkg::ERR_GROUP;
            halted_nxt    = 1'b1;
          end else begin
            push_cmd.last_idx = fbd_pkg::IDX_TWO;
            push_cmd.bytes[1] = {grp_r[1].val[3:0], grp_r[2].val[5:2]};
          end
        end else begin
          push_cmd.last_idx = fbd_pkg::IDX_THREE;
          push_cmd.bytes[1] = {grp_r[1].val[3:0], grp_r[2].val[5:2]};
          push_cmd.bytes[2] = {grp_r[2].val[1:0], s_in.val};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r <= 1'b0;
      halted_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      inside_r <= inside_nxt;
      halted_r <= halted_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      grp_r[cnt_r] <= s_in;
    end
  end

endmodule

FILE: sv/fbd_queue.sv
// short request queue between the front and back ends
module fbd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  fbd_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output fbd_pkg::cmd_t head_cmd
);

  fbd_pkg::cmd_t               mem_r [fbd_pkg::Q_DEPTH];
  fbd_pkg::cmd_t               head_r;
  logic                        head_valid_r, head_valid_nxt;
  logic [fbd_pkg::Q_AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [fbd_pkg::Q_CW-1:0]    cnt_r, cnt_nxt;
  logic                        head_free;
  logic                        rd_mem;
  logic                        bypass;
  logic                        wr_mem;

  // head register in front of the storage; an empty queue loads it directly
  assign full       = cnt_r == fbd_pkg::Q_CW'(fbd_pkg::Q_DEPTH);
  assign head_valid = head_valid_r;
  assign head_cmd   = head_r;
  assign head_free  = !head_valid_r || pop;
  assign rd_mem     = head_free && (cnt_r != '0);
  assign bypass     = head_free && (cnt_r == '0) && push;
  assign wr_mem     = push && !bypass;

  always_comb begin
    cnt_nxt        = cnt_r;
    head_valid_nxt = head_valid_r;
    if (wr_mem && !rd_mem) begin
      cnt_nxt = cnt_r + fbd_pkg::Q_CW'(1);
    end else if (rd_mem && !wr_mem) begin
      cnt_nxt = cnt_r - fbd_pkg::Q_CW'(1);
    end
    if (head_free) begin
      head_valid_nxt = rd_mem || bypass;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r     <= '0;
      rd_ptr_r     <= '0;
      cnt_r        <= '0;
      head_valid_r <= 1'b0;
    end else begin
      cnt_r        <= cnt_nxt;
      head_valid_r <= head_valid_nxt;
      if (wr_mem) begin
        wr_ptr_r <= (wr_ptr_r == fbd_pkg::Q_AW'(fbd_pkg::Q_DEPTH - 1)) ? '0 :
                    wr_ptr_r + fbd_pkg::Q_AW'(1);
      end
      if (rd_mem) begin
        rd_ptr_r <= (rd_ptr_r == fbd_pkg::Q_AW'(fbd_pkg::Q_DEPTH - 1)) ? '0 :
                    rd_ptr_r + fbd_pkg::Q_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_mem) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
    if (rd_mem) begin
      head_r <= mem_r[rd_ptr_r];
    end else if (bypass) begin
      head_r <= push_cmd;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= fbd_pkg::Q_CW'(fbd_pkg::Q_DEPTH))
    else $error("queue count out of range");
  a_head_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (head_valid && !pop) |=> (head_valid && head_cmd == $past(head_cmd)))
    else $error("queue head changed before pop");
`endif

endmodule

FILE: sv/fbd_back.sv
// back end: spreads each request over its results into the output register
module fbd_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          head_valid,
  input  fbd_pkg::cmd_t head_cmd,
  output logic          pop,
  fbd_out_if.source     out_ch
);

  logic       out_valid_r, out_valid_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       load;
  logic       at_last;
  logic [7:0] sel_byte;
  logic [7:0] data_r;
  logic [1:0] kind_r;
  logic [1:0] err_r;
  logic       last_r;

  assign load    = head_valid && (!out_valid_r || out_ch.ready);
  assign at_last = idx_r == head_cmd.last_idx;
  assign pop     = load && at_last;

  always_comb begin
    case (idx_r)
      2'd0:    sel_byte = head_cmd.bytes[0];
      2'd1:    sel_byte = head_cmd.bytes[1];
      2'd2:    sel_byte = head_cmd.bytes[2];
      default: sel_byte = 8'd0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    idx_nxt       = idx_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = at_last ? 2'd0 : idx_r + 2'd1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= sel_byte;
      kind_r <= head_cmd.kind;
      err_r  <= head_cmd.err;
      last_r <= at_last;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.data_byte  = data_r;
  assign out_ch.kind       = kind_r;
  assign out_ch.error_code = err_r;
  assign out_ch.last       = last_r;

endmodule

FILE: sv/framed_base64_stream_decoder.sv
// top level of the framed base64 stream decoder
//
// in_ch carries one byte per request (or a stream end mark when stream_end
// is set); out_ch carries decoded bytes, frame-ended and stream-end marks
// and error reports, with last set on the final result of each queued request.
// the front end takes one input per cycle whenever the request queue has
// room, checks framing and characters, and decodes each complete group of
// four characters into one queued request of one to three results.
// the back end emits one result per cycle, while out_ch is ready, from the
// queue head into an output register.
// the first result of an input passes the queue head register and then the
// output register. throughput: one input per cycle; a group of four characters
// gives up to three results, so a long run of data keeps pace with the input.
// when out_ch stalls, the queue (four entries plus a head register) fills
// and in_ch.ready drops.
// reset clears framing state, the queue and the output register; after an
// error or stream end the block produces nothing more until reset.
module framed_base64_stream_decoder (
  input  logic       clk,
  input  logic       rst_n,
  fbd_in_if.sink     in_ch,
  fbd_out_if.source  out_ch
);

  logic          push;
  fbd_pkg::cmd_t push_cmd;
  logic          q_full;
  logic          pop;
  logic          head_valid;
  fbd_pkg::cmd_t head_cmd;

  fbd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  fbd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  fbd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule
